// ===== design/smg_pkg.sv =====
// smg_pkg: shared types and constants of the stepper step/dir move generator
// no dependencies; compiled first
`default_nettype none

package smg_pkg;

    // command codes of the mode field
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_REL  = 2'd1,
        MODE_ABS  = 2'd2,
        MODE_HOME = 2'd3
    } mode_t;

    // motion phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SETUP = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    // sequencer state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2
    } seq_state_t;

    // configuration register indexes
    localparam logic [1:0] REG_SPEED_RPM     = 2'd0;
    localparam logic [1:0] REG_STEPS_PER_REV = 2'd1;
    localparam logic [1:0] REG_DRIVE_ENABLE  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // field and datapath widths
    localparam int POS_W  = 32;
    localparam int RPM_W  = 10;
    localparam int SPR_W  = 16;
    localparam int TICK_W = 26;
    localparam int DEN_W  = RPM_W + SPR_W + 1;
    localparam int QUO_W  = 26;
    localparam int QCNT_W = 5;

    // ticks per minute, dividend of the half period
    localparam logic [QUO_W-1:0] TICKS_PER_MIN = 26'd60000000;

    // one result item
    typedef struct packed {
        logic             step_level;
        logic             dir_level;
        logic [POS_W-1:0] position;
        logic             moving;
        logic             homed;
    } res_t;

endpackage

`default_nettype wire

// ===== design/smg_if.sv =====
// smg_if: valid/ready channel interfaces for commands and results
// depends on smg_pkg
`default_nettype none

interface smg_in_if;
    import smg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic signed [POS_W-1:0] move_value;

    modport source (output valid, mode, move_value, input ready);
    modport sink   (input valid, mode, move_value, output ready);
endinterface

interface smg_out_if;
    import smg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    step_level;
    logic                    dir_level;
    logic signed [POS_W-1:0] position;
    logic                    moving;
    logic                    homed;

    modport source (output valid, step_level, dir_level, position, moving, homed,
                    input ready);
    modport sink   (input valid, step_level, dir_level, position, moving, homed,
                    output ready);
endinterface

`default_nettype wire

// ===== design/smg_div.sv =====
// smg_div: restoring divider, one quotient bit per cycle, ticks per minute / divisor
// depends on smg_pkg
`default_nettype none

module smg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [smg_pkg::DEN_W-1:0] divisor,
    output logic                           done,
    output logic [smg_pkg::QUO_W-1:0]      quotient
);
    import smg_pkg::*;

    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // start loads the dividend, else one shift and trial subtract while busy
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = TICKS_PER_MIN;
            cnt_next  = QCNT_W'(QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            else
                rem_next = trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/smg_obuf.sv =====
// smg_obuf: result output register with a one-entry hold stage
// depends on smg_pkg and smg_if
`default_nettype none

module smg_obuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire smg_pkg::res_t wr_data,
    output logic               full,
    smg_out_if.source          status
);
    import smg_pkg::*;

    res_t out_reg, out_next;
    res_t hold_reg, hold_next;
    logic out_valid_reg, out_valid_next;
    logic hold_valid_reg, hold_valid_next;
    logic take;

    // output register loads from hold first, else from the write
    always_comb
    begin
        take            = out_valid_reg && status.ready;
        out_next        = out_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        if (take || !out_valid_reg)
        begin
            if (hold_valid_reg)
            begin
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (wr)
            begin
                out_next       = wr_data;
                out_valid_next = 1'b1;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (wr)
        begin
            hold_next       = wr_data;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign full              = hold_valid_reg;
    assign status.valid      = out_valid_reg;
    assign status.step_level = out_reg.step_level;
    assign status.dir_level  = out_reg.dir_level;
    assign status.position   = out_reg.position;
    assign status.moving     = out_reg.moving;
    assign status.homed      = out_reg.homed;

endmodule

`default_nettype wire

// ===== design/stepper_step_dir_move_generator_core.sv =====
// stepper_step_dir_move_generator_core: top level, command sequencer and motion state
// depends on smg_pkg, smg_if, smg_div and smg_obuf
`default_nettype none

// Step/dir move generator. Each command transfer on cmd gives exactly one
// status transfer carrying the step and direction levels, position, moving
// and homed flags after that command. Ticks, set-home and ignored moves write
// their result when accepted. A move that starts is accepted, loads the restoring
// divider with the doubled rpm times steps-per-rev product, takes the quotient
// bits at one bit per cycle, then latches the half period and writes the result.
// Results go through an output register plus a one-entry hold, so a new command
// is taken while one result waits. The user writes configuration registers through
// cfg_we, cfg_index and cfg_data only while the block is idle, which the block
// itself does not enforce; unknown indexes are dropped.

module stepper_step_dir_move_generator_core #(
    parameter int MAX_RPM         = 1000,
    parameter int DIR_SETUP_TICKS = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [smg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smg_pkg::CFG_DATA_W-1:0] cfg_data,
    smg_in_if.sink                              cmd,
    smg_out_if.source                           status
);
    import smg_pkg::*;

    localparam logic [TICK_W-1:0] SETUP_TICKS = TICK_W'(DIR_SETUP_TICKS);
    localparam logic [16:0]       RPM_LIMIT   = 17'(MAX_RPM);

    // configuration
    logic [RPM_W-1:0] speed_rpm_reg;
    logic [SPR_W-1:0] steps_per_rev_reg;
    logic             drive_enable_reg;

    // motion state
    logic [POS_W-1:0]  position_reg, position_next;
    logic [POS_W-1:0]  pending_reg, pending_next;
    logic [POS_W-1:0]  pulses_reg, pulses_next;
    logic [TICK_W-1:0] half_reg, half_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    phase_t            phase_reg, phase_next;
    logic              dir_reg, dir_next;
    logic              step_reg, step_next;
    logic              homed_reg, homed_next;

    seq_state_t state_reg, state_next;

    logic                   accept;
    logic                   res_wr;
    logic                   move_go;
    res_t                   res_data;
    logic                   obuf_full;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_W-1:0]       div_q;
    logic [DEN_W-1:0]       denom;
    logic [RPM_W-1:0]       rpm_c;
    logic [SPR_W-1:0]       spr_c;
    logic [RPM_W+SPR_W-1:0] prod;
    logic [TICK_W-1:0]      tick_inc;
    logic [POS_W-1:0]       delta;
    logic [POS_W-1:0]       pulses_dec;

    assign accept = cmd.valid && cmd.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_rpm_reg     <= RPM_W'(60);
            steps_per_rev_reg <= SPR_W'(200);
            drive_enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_RPM:     speed_rpm_reg     <= cfg_data[RPM_W-1:0];
                REG_STEPS_PER_REV: steps_per_rev_reg <= cfg_data[SPR_W-1:0];
                REG_DRIVE_ENABLE:  drive_enable_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // clamped speed and steps, doubled product feeds the divider
    always_comb
    begin
        if (speed_rpm_reg == '0)
            rpm_c = RPM_W'(1);
        else if ({7'd0, speed_rpm_reg} > RPM_LIMIT)
            rpm_c = RPM_LIMIT[RPM_W-1:0];
        else
            rpm_c = speed_rpm_reg;
        spr_c = (steps_per_rev_reg == '0) ? SPR_W'(1) : steps_per_rev_reg;
        prod  = (RPM_W+SPR_W)'(rpm_c) * (RPM_W+SPR_W)'(spr_c);
        denom = {prod, 1'b0};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (move_go) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE) && !obuf_full;
        div_start = (state_reg == ST_MUL);
    end

    // command and tick handling
    always_comb
    begin
        position_next = position_reg;
        pending_next  = pending_reg;
        pulses_next   = pulses_reg;
        half_next     = half_reg;
        tick_next     = tick_reg;
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        step_next     = step_reg;
        homed_next    = homed_reg;
        res_wr        = 1'b0;
        move_go       = 1'b0;
        tick_inc      = tick_reg + 1'b1;
        pulses_dec    = pulses_reg - 1'b1;
        delta         = (mode_t'(cmd.mode) == MODE_REL) ? cmd.move_value
                                                        : cmd.move_value - position_reg;
        if (state_reg == ST_IDLE && accept)
        begin
            case (mode_t'(cmd.mode))
                MODE_TICK:
                begin
                    res_wr = 1'b1;
                    case (phase_reg)
                        PH_SETUP:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= SETUP_TICKS)
                            begin
                                phase_next = PH_HIGH;
                                step_next  = 1'b1;
                                tick_next  = '0;
                            end
                        end
                        PH_HIGH:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= half_reg)
                            begin
                                phase_next = PH_LOW;
                                step_next  = 1'b0;
                                tick_next  = '0;
                            end
                        end
                        PH_LOW:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= half_reg)
                            begin
                                pulses_next = pulses_dec;
                                tick_next   = '0;
                                if (pulses_dec == '0)
                                begin
                                    position_next = position_reg + pending_reg;
                                    pending_next  = '0;
                                    dir_next      = 1'b0;
                                    step_next     = 1'b0;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_HIGH;
                                    step_next  = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_REL, MODE_ABS:
                begin
                    if (drive_enable_reg && delta != '0 && phase_reg == PH_IDLE)
                    begin
                        move_go      = 1'b1;
                        pending_next = delta;
                        dir_next     = !delta[POS_W-1];
                        pulses_next  = delta[POS_W-1] ? (~delta + 1'b1) : delta;
                    end
                    else
                        res_wr = 1'b1;
                end
                MODE_HOME:
                begin
                    position_next = '0;
                    homed_next    = 1'b1;
                    res_wr        = 1'b1;
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            // latch the half period, zero raised to one
            half_next = (div_q == '0) ? TICK_W'(1) : div_q;
            tick_next = '0;
            res_wr    = 1'b1;
            if (DIR_SETUP_TICKS == 0)
            begin
                phase_next = PH_HIGH;
                step_next  = 1'b1;
            end
            else
            begin
                phase_next = PH_SETUP;
                step_next  = 1'b0;
            end
        end
    end

    // result of the command, state after it
    always_comb
    begin
        res_data.step_level = step_next;
        res_data.dir_level  = dir_next;
        res_data.position   = position_next;
        res_data.moving     = (phase_next != PH_IDLE);
        res_data.homed      = homed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            position_reg <= '0;
            pending_reg  <= '0;
            pulses_reg   <= '0;
            half_reg     <= '0;
            tick_reg     <= '0;
            phase_reg    <= PH_IDLE;
            dir_reg      <= 1'b0;
            step_reg     <= 1'b0;
            homed_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
            pending_reg  <= pending_next;
            pulses_reg   <= pulses_next;
            half_reg     <= half_next;
            tick_reg     <= tick_next;
            phase_reg    <= phase_next;
            dir_reg      <= dir_next;
            step_reg     <= step_next;
            homed_reg    <= homed_next;
        end
    end

    smg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (denom),
        .done     (div_done),
        .quotient (div_q)
    );

    smg_obuf u_obuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .full    (obuf_full),
        .status  (status)
    );

endmodule

`default_nettype wire

// ===== tb/tb_stepper_step_dir_move_generator_core.sv =====
// tb_stepper_step_dir_move_generator_core: self-checking bench for the step/dir move generator
// drives command transfers, predicts every status transfer and compares field by field
// depends on smg_pkg, smg_if and the core
`timescale 1ns / 100ps

module tb_stepper_step_dir_move_generator_core;
    import smg_pkg::*;

    localparam int TB_MAX_RPM     = 1000;
    localparam int SETUP_TICKS    = 5;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 70;
    localparam int DISABLED_ITEMS = 30;
    localparam int BURST_MIN      = 50;

    // index that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one row of the directed plan: a register write or a run of identical commands
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        mode_t                 mode;
        logic [POS_W-1:0]      value;
        int                    reps;
        bit                    typed;
        res_t                  want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smg_in_if  cmd_if ();
    smg_out_if status_if ();

    stepper_step_dir_move_generator_core #(
        .MAX_RPM         (TB_MAX_RPM),
        .DIR_SETUP_TICKS (SETUP_TICKS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .status    (status_if)
    );

    // register mirror
    logic [RPM_W-1:0] rpm_cfg;
    logic [SPR_W-1:0] spr_cfg;
    logic             enable_cfg;

    // motion state mirror
    logic [POS_W-1:0]  pos_q;
    logic [POS_W-1:0]  pend_delta;
    logic [POS_W-1:0]  pulses_left;
    logic [TICK_W-1:0] half_per;
    logic [TICK_W-1:0] tick_cnt;
    phase_t            phase_q;
    logic              dir_q;
    logic              step_q;
    logic              homed_q;

    res_t expected_status_q[$];
    bit   no_idle;
    int   error_count;
    int   items_sent;
    int   status_checked;
    int   moves_started;
    int   moves_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the motion mirror by one command and return the status it leaves
    task automatic advance_motion(input mode_t m, input logic [POS_W-1:0] v, output res_t r);
        logic [POS_W-1:0] delta;
        longint unsigned  rpm_eff;
        longint unsigned  spr_eff;
        longint unsigned  quo;
        delta = (m == MODE_ABS) ? v - pos_q : v;
        if (m == MODE_TICK)
        begin
            if (phase_q != PH_IDLE)
            begin
                tick_cnt = tick_cnt + 1'b1;
                case (phase_q)
                    PH_SETUP:
                    begin
                        if (tick_cnt >= SETUP_TICKS)
                        begin
                            phase_q  = PH_HIGH;
                            step_q   = 1'b1;
                            tick_cnt = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (tick_cnt >= half_per)
                        begin
                            phase_q  = PH_LOW;
                            step_q   = 1'b0;
                            tick_cnt = '0;
                        end
                    end
                    default:
                    begin
                        if (tick_cnt >= half_per)
                        begin
                            pulses_left = pulses_left - 1'b1;
                            tick_cnt    = '0;
                            if (pulses_left == '0)
                            begin
                                // last low half done: commit the move
                                pos_q      = pos_q + pend_delta;
                                pend_delta = '0;
                                dir_q      = 1'b0;
                                step_q     = 1'b0;
                                phase_q    = PH_IDLE;
                                moves_done++;
                            end
                            else
                            begin
                                phase_q = PH_HIGH;
                                step_q  = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        else if (m == MODE_HOME)
        begin
            pos_q   = '0;
            homed_q = 1'b1;
        end
        else if (enable_cfg && delta != '0 && phase_q == PH_IDLE)
        begin
            // move start: latch direction, pulse count and half period
            pend_delta  = delta;
            dir_q       = ~delta[POS_W-1];
            pulses_left = delta[POS_W-1] ? ('0 - delta) : delta;
            rpm_eff     = (rpm_cfg == '0) ? 1 : rpm_cfg;
            if (rpm_eff > TB_MAX_RPM)
                rpm_eff = TB_MAX_RPM;
            spr_eff     = (spr_cfg == '0) ? 1 : spr_cfg;
            quo         = longint'(TICKS_PER_MIN) / (rpm_eff * spr_eff * 2);
            if (quo == 0)
                quo = 1;
            half_per    = quo[TICK_W-1:0];
            tick_cnt    = '0;
            step_q      = 1'b0;
            if (SETUP_TICKS == 0)
            begin
                phase_q = PH_HIGH;
                step_q  = 1'b1;
            end
            else
                phase_q = PH_SETUP;
            moves_started++;
        end
        r.step_level = step_q;
        r.dir_level  = dir_q;
        r.position   = pos_q;
        r.moving     = (phase_q != PH_IDLE);
        r.homed      = homed_q;
    endtask

    // one command transfer; valid stays high when the next command follows at once
    task automatic send_cmd(input mode_t m, input logic [POS_W-1:0] v, input bit typed,
                            input res_t want);
        int   gap;
        res_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= m;
        cmd_if.move_value <= v;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        advance_motion(m, v, pred);
        expected_status_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // register write once every status transfer is in
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cmd_if.valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SPEED_RPM:     rpm_cfg    = data[RPM_W-1:0];
            REG_STEPS_PER_REV: spr_cfg    = data[SPR_W-1:0];
            REG_DRIVE_ENABLE:  enable_cfg = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // compare a status transfer with the oldest expectation
    task automatic check_status(input res_t got);
        res_t want;
        status_checked++;
        if (expected_status_q.size() == 0)
        begin
            if (error_count < MAX_REPORTS)
                $display("ERROR: status transfer with nothing pending, got %h", got);
            error_count++;
        end
        else
        begin
            want = expected_status_q.pop_front();
            if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
                got.position !== want.position || got.moving !== want.moving ||
                got.homed !== want.homed)
            begin
                if (error_count < MAX_REPORTS)
                    $display("ERROR: status #%0d step %b/%b dir %b/%b pos %h/%h moving %b/%b homed %b/%b (exp/act)",
                             status_checked, want.step_level, got.step_level, want.dir_level,
                             got.dir_level, want.position, got.position, want.moving,
                             got.moving, want.homed, got.homed);
                error_count++;
            end
        end
    endtask

    // directed plan rows
    function automatic stim_row_t cmd_row(input mode_t m, input logic [POS_W-1:0] v,
                                          input int reps);
        stim_row_t row;
        row.is_cfg   = 1'b0;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.mode     = m;
        row.value    = v;
        row.reps     = reps;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input mode_t m, input logic [POS_W-1:0] v,
                                            input res_t want);
        stim_row_t row;
        row       = cmd_row(m, v, 1);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row          = cmd_row(MODE_TICK, '0, 0);
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    // status sink with random stalls per transfer
    initial
    begin : status_sink
        int stall;
        status_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                status_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            status_if.ready <= 1'b1;
            @(posedge clk);
            while (!status_if.valid)
                @(posedge clk);
            check_status({status_if.step_level, status_if.dir_level, status_if.position,
                          status_if.moving, status_if.homed});
        end
    end

    // run limit
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("FAIL stepper_step_dir_move_generator_core");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        stim_row_t        plan[$];
        mode_t            m;
        logic [POS_W-1:0] v;
        int               r;
        int               n;
        int               items;

        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.mode       = MODE_TICK;
        cmd_if.move_value = '0;
        rst_n             = 1'b0;
        no_idle           = 1'b0;
        error_count       = 0;
        items_sent        = 0;
        status_checked    = 0;
        moves_started     = 0;
        moves_done        = 0;

        // reset values of registers and motion state
        rpm_cfg     = 10'd60;
        spr_cfg     = 16'd200;
        enable_cfg  = 1'b1;
        pos_q       = '0;
        pend_delta  = '0;
        pulses_left = '0;
        half_per    = '0;
        tick_cnt    = '0;
        phase_q     = PH_IDLE;
        dir_q       = 1'b0;
        step_q      = 1'b0;
        homed_q     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan; status is {step, dir, position, moving, homed}
        // tick while idle, set home, zero-length move
        plan.push_back(known_row(MODE_TICK, 32'd0, {1'b0, 1'b0, 32'd0, 1'b0, 1'b0}));
        plan.push_back(known_row(MODE_HOME, 32'd0, {1'b0, 1'b0, 32'd0, 1'b0, 1'b1}));
        plan.push_back(known_row(MODE_REL, 32'd0, {1'b0, 1'b0, 32'd0, 1'b0, 1'b1}));
        // moves ignored while disabled, field extremes
        plan.push_back(reg_row(REG_DRIVE_ENABLE, 16'd0));
        plan.push_back(known_row(MODE_REL, 32'h7FFF_FFFF, {1'b0, 1'b0, 32'd0, 1'b0, 1'b1}));
        plan.push_back(known_row(MODE_ABS, 32'h8000_0000, {1'b0, 1'b0, 32'd0, 1'b0, 1'b1}));
        // speed above maximum, largest steps per rev, dropped index
        plan.push_back(reg_row(REG_DRIVE_ENABLE, 16'd1));
        plan.push_back(reg_row(REG_SPEED_RPM, 16'd1023));
        plan.push_back(reg_row(REG_STEPS_PER_REV, 16'hFFFF));
        plan.push_back(reg_row(REG_UNUSED, 16'd0));
        plan.push_back(known_row(MODE_REL, 32'd3, {1'b0, 1'b1, 32'd0, 1'b1, 1'b1}));
        // move while running is dropped, disable mid-move lets it finish
        plan.push_back(cmd_row(MODE_REL, 32'h8000_0000, 1));
        plan.push_back(cmd_row(MODE_TICK, 32'd0, 4));
        plan.push_back(reg_row(REG_DRIVE_ENABLE, 16'd0));
        plan.push_back(cmd_row(MODE_TICK, 32'd0, 14));
        plan.push_back(reg_row(REG_DRIVE_ENABLE, 16'd1));
        // negative absolute move with set home in the middle
        plan.push_back(cmd_row(MODE_ABS, 32'hFFFF_FFFE, 1));
        plan.push_back(cmd_row(MODE_TICK, 32'd0, 6));
        plan.push_back(cmd_row(MODE_HOME, 32'd0, 1));
        plan.push_back(cmd_row(MODE_TICK, 32'd0, 14));
        plan.push_back(known_row(MODE_ABS, 32'hFFFF_FFFB, {1'b0, 1'b0, 32'hFFFF_FFFB, 1'b0, 1'b1}));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            else
            begin
                no_idle = (plan[i].reps > BURST_MIN);
                for (int k = 0; k < plan[i].reps; k++)
                    send_cmd(plan[i].mode, plan[i].value, plan[i].typed, plan[i].want);
            end
        end
        no_idle = 1'b0;

        // random phases, each with fresh speed settings; one phase disabled, one without gaps
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(REG_SPEED_RPM, CFG_DATA_W'($urandom_range(500, 1023)));
            write_reg(REG_STEPS_PER_REV, CFG_DATA_W'($urandom_range(7500, 65535)));
            write_reg(REG_DRIVE_ENABLE, (p == 3) ? 16'd0 : 16'd1);
            no_idle = (p == 2);
            items   = (p == 3) ? DISABLED_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++)
            begin
                r = $urandom_range(0, 99);
                v = '0;
                if (r < 60)
                    m = MODE_TICK;
                else if (r < 72)
                begin
                    // short relative move in either direction
                    m = MODE_REL;
                    v = $urandom_range(1, 4);
                    if ($urandom_range(0, 1))
                        v = '0 - v;
                end
                else if (r < 82)
                begin
                    // absolute target near the current position, sometimes equal
                    m = MODE_ABS;
                    v = pos_q + POS_W'($urandom_range(0, 8)) - POS_W'(4);
                end
                else if (r < 87)
                    m = MODE_HOME;
                else if (phase_q != PH_IDLE || !enable_cfg)
                begin
                    // full-width value on a move that is bound to be dropped
                    m = $urandom_range(0, 1) ? MODE_REL : MODE_ABS;
                    v = $urandom();
                end
                else
                    m = MODE_TICK;
                send_cmd(m, v, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        // let the last move finish, then start a most-negative move that never ends
        // with zero speed and zero steps per rev, both counted as one
        while (phase_q != PH_IDLE)
            send_cmd(MODE_TICK, '0, 1'b0, '0);
        write_reg(REG_DRIVE_ENABLE, 16'd1);
        write_reg(REG_SPEED_RPM, 16'd0);
        write_reg(REG_STEPS_PER_REV, 16'd0);
        send_cmd(MODE_REL, 32'h8000_0000, 1'b0, '0);
        for (int k = 0; k < 12; k++)
            send_cmd(MODE_TICK, '0, 1'b0, '0);
        send_cmd(MODE_ABS, 32'h7FFF_FFFF, 1'b0, '0);
        cmd_if.valid <= 1'b0;

        // drain
        n = 0;
        while (expected_status_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_status_q.size() != 0)
        begin
            $display("ERROR: %0d status transfers never arrived", expected_status_q.size());
            error_count += expected_status_q.size();
        end

        $display("run: %0d commands sent, %0d status transfers checked, %0d errors",
                 items_sent, status_checked, error_count);
        $display("run: %0d moves started, %0d finished, over clamped and random speed settings",
                 moves_started, moves_done);
        if (error_count == 0)
            $display("PASS stepper_step_dir_move_generator_core");
        else
            $display("FAIL stepper_step_dir_move_generator_core");
        $finish;
    end

endmodule
